// File: rtl/ssps_pkg.sv
// Shared types, constants and helper functions for the stimulus pulse scheduler.
package ssps_pkg;

    // Number of stimulus channels; only the first four have configuration bytes.
    localparam int CHANNELS     = 4;
    localparam int REG_CHANNELS = 4;
    localparam int CNT_W        = $clog2(CHANNELS + 1);
    localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Timing constants, in ticks.
    localparam logic [7:0] UNSCHED_DELAY       = 8'hFF;
    localparam logic [7:0] DEFAULT_DIVISOR     = 8'd1;
    localparam logic [7:0] RAMP_LEAD_TICKS     = 8'd2;
    localparam logic [7:0] DISCHARGE_MIN_TICKS = 8'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_STIM_DELAYS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_DIVISORS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_SYNC_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AUTO_SYNCS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_WAIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_ANODE      = 3'd5;

    // Configuration reset values.
    localparam logic [31:0] RST_STIM_DELAYS    = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_SYNC_DIVISORS  = 32'h0101_0101;
    localparam logic [7:0]  RST_AUTO_SYNC_LIM  = 8'hFF;
    localparam logic [7:0]  RST_MAX_AUTO_SYNCS = 8'hFF;
    localparam logic [7:0]  RST_DISCHARGE_WAIT = 8'h00;

    // Device mode codes.
    localparam logic [1:0] MODE_PATIENT = 2'd1;
    localparam logic [1:0] MODE_WAITING = 2'd2;

    // Supply step codes.
    localparam logic [1:0] STEP_NONE      = 2'd0;
    localparam logic [1:0] STEP_RAMP_UP   = 2'd1;
    localparam logic [1:0] STEP_RAMP_DOWN = 2'd2;

    // Anode command codes.
    localparam logic [1:0] ANODE_NONE    = 2'd0;
    localparam logic [1:0] ANODE_ENABLE  = 2'd1;
    localparam logic [1:0] ANODE_DISABLE = 2'd2;

    // Sync kind codes.
    localparam logic [1:0] SYNC_NONE    = 2'd0;
    localparam logic [1:0] SYNC_REAL    = 2'd1;
    localparam logic [1:0] SYNC_AUTO    = 2'd2;
    localparam logic [1:0] SYNC_OVERRUN = 2'd3;

    // Input word: one millisecond tick.
    typedef struct packed {
        logic       sync_seen;
        logic [1:0] device_mode;
        logic       supply_ready;
        logic [3:0] setup_done_mask;
    } in_word_t;

    // Result word for one tick.
    typedef struct packed {
        logic        fire_valid;
        logic [1:0]  fire_channel;
        logic [7:0]  fire_tick;
        logic [7:0]  fire_tick_max;
        logic [1:0]  supply_step;
        logic        supply_off;
        logic        discharge_open;
        logic [1:0]  anode_cmd;
        logic [1:0]  sync_kind;
        logic [15:0] auto_sync_total;
        logic [15:0] overrun_total;
        logic [31:0] time_ms;
    } out_word_t;

    // Configuration register contents.
    typedef struct packed {
        logic [31:0] stim_delays;
        logic [31:0] sync_divisors;
        logic [7:0]  auto_sync_limit_ticks;
        logic [7:0]  max_auto_syncs;
        logic [7:0]  discharge_wait;
        logic        use_anode;
    } cfg_t;

    // Per-tick control from the scheduler to each channel.
    typedef struct packed {
        logic advance;  // a tick is being retired this cycle
        logic start;    // a period opens on this tick
        logic count;    // the tick was not aborted by an overrun
    } chan_ctrl_t;

    // Channel status after the period start and tick count of this tick.
    typedef struct packed {
        logic       hit;    // armed and delay reached
        logic       ready;  // setup done
        logic [7:0] ticks;  // channel tick count
        logic [7:0] peak;   // peak fire tick if the channel fires now
    } chan_stat_t;

    // Delay byte of a channel; channels without a byte are unscheduled.
    function automatic logic [7:0] chan_delay(input logic [31:0] r, input int i);
        logic [7:0] b;
        b = 8'(r >> (8 * (i % REG_CHANNELS)));
        return (i < REG_CHANNELS) ? b : UNSCHED_DELAY;
    endfunction

    // Divisor byte of a channel; channels without a byte arm on every sync.
    function automatic logic [7:0] chan_divisor(input logic [31:0] r, input int i);
        logic [7:0] b;
        b = 8'(r >> (8 * (i % REG_CHANNELS)));
        return (i < REG_CHANNELS) ? b : DEFAULT_DIVISOR;
    endfunction

endpackage

// File: rtl/ssps_cfg_regs.sv
// Configuration register bank of the stimulus pulse scheduler.
module ssps_cfg_regs
    import ssps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and merge the written word.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_STIM_DELAYS:    cfg_next.stim_delays           = cfg_wr_data;
                CFG_SYNC_DIVISORS:  cfg_next.sync_divisors         = cfg_wr_data;
                CFG_AUTO_SYNC_LIM:  cfg_next.auto_sync_limit_ticks = cfg_wr_data[7:0];
                CFG_MAX_AUTO_SYNCS: cfg_next.max_auto_syncs        = cfg_wr_data[7:0];
                CFG_DISCHARGE_WAIT: cfg_next.discharge_wait        = cfg_wr_data[7:0];
                CFG_USE_ANODE:      cfg_next.use_anode             = cfg_wr_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Registers come out of reset with their documented defaults.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stim_delays           <= RST_STIM_DELAYS;
            cfg_reg.sync_divisors         <= RST_SYNC_DIVISORS;
            cfg_reg.auto_sync_limit_ticks <= RST_AUTO_SYNC_LIM;
            cfg_reg.max_auto_syncs        <= RST_MAX_AUTO_SYNCS;
            cfg_reg.discharge_wait        <= RST_DISCHARGE_WAIT;
            cfg_reg.use_anode             <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/ssps_chan.sv
// One stimulus channel: sync tally, arming, tick count, setup flag and peak fire tick.
module ssps_chan
    import ssps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  chan_ctrl_t ctrl,
    input  logic       fire,
    input  logic       setup_done,
    input  logic [7:0] delay,
    input  logic [7:0] divisor,
    output chan_stat_t stat
);

    logic [7:0] tally_reg, tally_next;
    logic       armed_reg, armed_next;
    logic [7:0] ticks_reg, ticks_next;
    logic       ready_reg, ready_next;
    logic [7:0] peak_reg, peak_next;

    logic [7:0] tally_inc;
    logic       rearm;
    logic       armed_mid;
    logic [7:0] ticks_mid;
    logic       ready_mid;

    // Period start: count the sync and rearm on the divisor.
    always_comb begin
        tally_inc = tally_reg + 8'd1;
        rearm     = ctrl.start && (tally_inc >= divisor);
        armed_mid = armed_reg | rearm;
        ticks_mid = rearm ? 8'd0 : ticks_reg;
        ready_mid = rearm ? 1'b0 : (ready_reg | setup_done);
        if (ctrl.start) begin
            tally_next = rearm ? 8'd0 : tally_inc;
        end else begin
            tally_next = tally_reg;
        end
    end

    // Advance the tick count and report whether the delay is reached.
    always_comb begin
        ticks_next = (ctrl.count && armed_mid) ? ticks_mid + 8'd1 : ticks_mid;
        stat.hit   = armed_mid && (ticks_next >= delay);
        stat.ready = ready_mid;
        stat.ticks = ticks_next;
        stat.peak  = (ticks_next > peak_reg) ? ticks_next : peak_reg;
        armed_next = armed_mid & ~fire;
        ready_next = ready_mid;
        peak_next  = fire ? stat.peak : peak_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tally_reg <= 8'd0;
            armed_reg <= 1'b0;
            ticks_reg <= 8'd0;
            ready_reg <= 1'b0;
            peak_reg  <= 8'd0;
        end else if (ctrl.advance) begin
            tally_reg <= tally_next;
            armed_reg <= armed_next;
            ticks_reg <= ticks_next;
            ready_reg <= ready_next;
            peak_reg  <= peak_next;
        end
    end

endmodule

// File: rtl/sync_stim_pulse_scheduler.sv
// Top level of the stimulus pulse scheduler: tick pipeline, period logic and result word.
//
// Each input word is one 1 ms tick. The word is registered on acceptance, the whole
// tick is resolved by the period, channel and supply logic when it is retired, and
// the result word is registered on the output. One tick is retired per cycle, so
// a new word is accepted every cycle while the result side keeps up; a result waits in
// the output register while one further tick sits in the input register. Configuration
// writes take effect on the next cycle and are meant to happen only while no tick is
// in flight.
module sync_stim_pulse_scheduler
    import ssps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    cfg_t cfg;

    // Pipeline registers.
    logic      in_valid_reg, in_valid_next;
    in_word_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg, out_data_next;
    logic      advance;

    // Scheduler state.
    logic [31:0]      clock_ms_reg, clock_ms_next;
    logic [7:0]       period_ticks_reg, period_ticks_next;
    logic [7:0]       auto_run_reg, auto_run_next;
    logic [15:0]      auto_total_reg, auto_total_next;
    logic [15:0]      overrun_reg, overrun_next;
    logic [CNT_W-1:0] done_count_reg, done_count_next;
    logic             ramp_pending_reg, ramp_pending_next;
    logic [7:0]       discharge_ticks_reg, discharge_ticks_next;

    // Derived configuration.
    logic [7:0]       delay_arr [CHANNELS];
    logic [7:0]       divisor_arr [CHANNELS];
    logic [CHANNELS-1:0] setup_arr;
    logic [7:0]       vos_min;
    logic [7:0]       vos;
    logic [CNT_W-1:0] nsched;

    // Tick evaluation.
    in_word_t         tick;
    logic             auto_cond;
    logic [7:0]       auto_run_inc;
    logic             overrun;
    logic             start;
    logic             phase;
    logic             ramp;
    logic             fire_phase;
    logic [7:0]       dt_inc;
    logic             dis;
    logic             any_hit;
    logic [CH_W-1:0]  sel;
    logic             fire;
    logic [CNT_W-1:0] done_mid;
    logic [CNT_W-1:0] done_fire;
    logic             last_pulse;
    logic             ramp_pend_mid;
    logic [1:0]       kind;

    chan_ctrl_t          ctrl;
    chan_stat_t          stat [CHANNELS];
    logic [CHANNELS-1:0] fire_vec;

    ssps_cfg_regs u_cfg_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // Handshake: retire the held tick when the output register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign tick    = in_data_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Per-channel configuration bytes and setup flags.
    for (genvar i = 0; i < CHANNELS; i++) begin : g_cfg
        assign delay_arr[i]   = chan_delay(cfg.stim_delays, i);
        assign divisor_arr[i] = chan_divisor(cfg.sync_divisors, i);
        if (i < REG_CHANNELS) begin : g_mask
            assign setup_arr[i] = tick.setup_done_mask[i];
        end else begin : g_nomask
            assign setup_arr[i] = 1'b0;
        end
    end

    // Scheduled channel count and supply ramp lead time.
    always_comb begin
        vos_min = UNSCHED_DELAY;
        nsched  = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (delay_arr[i] != UNSCHED_DELAY) begin
                nsched = nsched + CNT_W'(1);
            end
            if (delay_arr[i] < vos_min) begin
                vos_min = delay_arr[i];
            end
        end
        vos = (vos_min > 8'd1) ? vos_min - RAMP_LEAD_TICKS : 8'd0;
    end

    // Period start: real sync, automatic sync or overrun abort.
    always_comb begin
        auto_cond    = (period_ticks_reg > cfg.auto_sync_limit_ticks)
                       && (tick.device_mode == MODE_PATIENT);
        auto_run_inc = auto_run_reg + 8'd1;
        overrun      = !tick.sync_seen && auto_cond && (auto_run_inc > cfg.max_auto_syncs);
        start        = tick.sync_seen || (auto_cond && !overrun);

        if (tick.sync_seen) begin
            auto_run_next = 8'd0;
            kind          = SYNC_REAL;
        end else if (auto_cond) begin
            auto_run_next = auto_run_inc;
            kind          = overrun ? SYNC_OVERRUN : SYNC_AUTO;
        end else begin
            auto_run_next = auto_run_reg;
            kind          = SYNC_NONE;
        end
        auto_total_next   = (!tick.sync_seen && auto_cond) ? auto_total_reg + 16'd1
                                                            : auto_total_reg;
        overrun_next      = overrun ? overrun_reg + 16'd1 : overrun_reg;
        period_ticks_next = overrun ? 8'd0 : (start ? 8'd0 : period_ticks_reg) + 8'd1;
        ramp_pend_mid     = start | ramp_pending_reg;
        done_mid          = start ? '0 : done_count_reg;
        clock_ms_next     = clock_ms_reg + 32'd1;
    end

    // Channel control shared by all channels.
    assign ctrl.advance = advance;
    assign ctrl.start   = start;
    assign ctrl.count   = !overrun;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
        assign fire_vec[i] = fire && (sel == CH_W'(i));
        ssps_chan u_chan (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .fire       (fire_vec[i]),
            .setup_done (setup_arr[i]),
            .delay      (delay_arr[i]),
            .divisor    (divisor_arr[i]),
            .stat       (stat[i])
        );
    end

    // Lowest-index channel whose delay is reached.
    always_comb begin
        any_hit = 1'b0;
        sel     = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (stat[i].hit) begin
                any_hit = 1'b1;
                sel     = CH_W'(i);
            end
        end
    end

    // Supply ramp, discharge switch and pulse firing.
    always_comb begin
        phase      = !overrun && tick.supply_ready;
        ramp       = phase && ramp_pend_mid && (period_ticks_next >= vos);
        fire_phase = phase && !ramp;
        dt_inc     = discharge_ticks_reg + 8'd1;
        dis        = fire_phase && (dt_inc > cfg.discharge_wait)
                     && (dt_inc > DISCHARGE_MIN_TICKS);
        fire       = fire_phase && any_hit && stat[sel].ready;
        done_fire  = done_mid + CNT_W'(1);
        last_pulse = fire && (done_fire == nsched);

        ramp_pending_next = ramp ? 1'b0 : ramp_pend_mid;
        done_count_next   = fire ? done_fire : done_mid;
        if (fire_phase) begin
            discharge_ticks_next = fire ? 8'd0 : dt_inc;
        end else begin
            discharge_ticks_next = discharge_ticks_reg;
        end
    end

    // Result word.
    always_comb begin
        out_data_next.fire_valid      = fire;
        out_data_next.fire_channel    = fire ? 2'(sel) : 2'd0;
        out_data_next.fire_tick       = fire ? stat[sel].ticks : 8'd0;
        out_data_next.fire_tick_max   = fire ? stat[sel].peak : 8'd0;
        out_data_next.supply_step     = ramp ? STEP_RAMP_UP
                                             : (last_pulse ? STEP_RAMP_DOWN : STEP_NONE);
        out_data_next.supply_off      = dis && (tick.device_mode == MODE_WAITING);
        out_data_next.discharge_open  = dis;
        if (!cfg.use_anode) begin
            out_data_next.anode_cmd = ANODE_NONE;
        end else if (ramp) begin
            out_data_next.anode_cmd = ANODE_ENABLE;
        end else if (last_pulse) begin
            out_data_next.anode_cmd = ANODE_DISABLE;
        end else begin
            out_data_next.anode_cmd = ANODE_NONE;
        end
        out_data_next.sync_kind       = kind;
        out_data_next.auto_sync_total = auto_total_next;
        out_data_next.overrun_total   = overrun_next;
        out_data_next.time_ms         = clock_ms_next;
    end

    // Handshake and scheduler state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            clock_ms_reg        <= 32'd0;
            period_ticks_reg    <= 8'd0;
            auto_run_reg        <= 8'd0;
            auto_total_reg      <= 16'd0;
            overrun_reg         <= 16'd0;
            done_count_reg      <= '0;
            ramp_pending_reg    <= 1'b0;
            discharge_ticks_reg <= 8'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                clock_ms_reg        <= clock_ms_next;
                period_ticks_reg    <= period_ticks_next;
                auto_run_reg        <= auto_run_next;
                auto_total_reg      <= auto_total_next;
                overrun_reg         <= overrun_next;
                done_count_reg      <= done_count_next;
                ramp_pending_reg    <= ramp_pending_next;
                discharge_ticks_reg <= discharge_ticks_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: rtl/ssps_checker.sv
// Port-level checker for the stimulus pulse scheduler and its bind statement.
module ssps_checker
    import ssps_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    logic        seen_reg;
    logic [31:0] last_time_reg;
    logic [15:0] last_over_reg;
    logic [15:0] over_step;

    // Remember the counters of the last delivered word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= 1'b0;
            last_time_reg <= 32'd0;
            last_over_reg <= 16'd0;
        end else if (m_valid && m_ready) begin
            seen_reg      <= 1'b1;
            last_time_reg <= m_data.time_ms;
            last_over_reg <= m_data.overrun_total;
        end
    end

    assign over_step = (m_data.sync_kind == SYNC_OVERRUN) ? 16'd1 : 16'd0;

    // Reset empties the result side.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Reset leaves the input side ready for a word.
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Every tick advances the millisecond clock by one.
    a_time_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_reg |-> m_data.time_ms == last_time_reg + 32'd1)
        else $error("millisecond clock skipped or repeated");

    // The overrun count moves only on an over-limit automatic sync.
    a_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_reg |-> m_data.overrun_total == last_over_reg + over_step)
        else $error("overrun count out of step with sync kind");

endmodule

bind sync_stim_pulse_scheduler ssps_checker u_ssps_checker (.*);
